>>> rtl/core/fcfr_pkg.sv
// Shared constants for the fridge command frame responder.
package fcfr_pkg;

	localparam int COUNT_BITS_DEF = 10;

	localparam logic [7:0] SYNC_BYTE = 8'hFE;

	localparam logic [7:0] OP_BIND   = 8'h00;
	localparam logic [7:0] OP_QUERY  = 8'h01;
	localparam logic [7:0] OP_SET    = 8'h02;
	localparam logic [7:0] OP_RESET  = 8'h04;
	localparam logic [7:0] OP_LEFT   = 8'h05;
	localparam logic [7:0] OP_RIGHT  = 8'h06;

	localparam logic [7:0] TARGET_RESET = 8'hF8;

	localparam logic [7:0] ACK_LEN_BYTE   = 8'h03;
	localparam logic [7:0] QUERY_LEN_BYTE = 8'd21;
	localparam logic [7:0] MIN_LEN        = 8'd3;
	localparam logic [7:0] SET_MIN_LEN    = 8'd21;
	localparam logic [7:0] LEFT_MIN_LEN   = 8'd4;

	localparam logic [7:0] QRY_BYTE_NINE   = 8'd10;
	localparam logic [7:0] QRY_BYTE_TEN    = 8'hE7;
	localparam logic [7:0] QRY_BYTE_ELEVEN = 8'd2;

	localparam logic signed [7:0] TARGET_MIN = -8'sd25;
	localparam logic signed [7:0] TARGET_MAX = 8'sd20;
	localparam logic signed [7:0] CABIN_MIN  = -8'sd40;
	localparam logic signed [7:0] CABIN_MAX  = 8'sd50;

	// Sum of the fixed bytes of each response frame.
	localparam logic [15:0] QUERY_SUM_BASE = 16'h0305;
	localparam logic [15:0] ACK_SUM_BASE   = 16'h01FF;

	localparam logic [4:0] QUERY_LAST_IDX = 5'd23;
	localparam logic [4:0] ACK_LAST_IDX   = 5'd5;

endpackage

>>> rtl/core/fcfr_if.sv
// Handshake channel interfaces for command bytes and response bytes.
interface fcfr_cmd_if;
	logic              valid;
	logic              ready;
	logic [7:0]        rx_byte;
	logic              frame_end;
	logic signed [7:0] current_temp;
	logic [6:0]        battery_percent;
	logic [4:0]        battery_volts;
	logic [3:0]        battery_tenths;

	modport source (
		output valid, rx_byte, frame_end, current_temp,
		       battery_percent, battery_volts, battery_tenths,
		input  ready
	);
	modport sink (
		input  valid, rx_byte, frame_end, current_temp,
		       battery_percent, battery_volts, battery_tenths,
		output ready
	);
endinterface

interface fcfr_resp_if;
	logic       valid;
	logic       ready;
	logic [7:0] resp_byte;
	logic       resp_last;
	logic       checksum_mismatch;

	modport source (
		output valid, resp_byte, resp_last, checksum_mismatch,
		input  ready
	);
	modport sink (
		input  valid, resp_byte, resp_last, checksum_mismatch,
		output ready
	);
endinterface

>>> rtl/core/fridge_command_frame_responder.sv
// Fridge command frame responder: frame gathering, decode and response serializer.
// Throughput: one command byte per cycle; a frame_end byte waits while an earlier
// response is still being serialized. The frame_end transfer starts the serializer,
// which loads one response byte per cycle into the output register unless resp.ready
// holds it off, 6 bytes for an acknowledgement and 24 for a status.
// Reset clears the frame gatherer and restores unlocked, powered, max cooling, -8 degrees.
module fridge_command_frame_responder #(
	parameter int COUNT_BITS = fcfr_pkg::COUNT_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	fcfr_cmd_if.sink     cmd,
	fcfr_resp_if.source  resp
);
	import fcfr_pkg::*;

	// One extra bit so that byte position plus one never wraps.
	localparam int CW = COUNT_BITS + 1;

	// Frame gathering state. It returns to its reset values after every frame_end.
	logic [COUNT_BITS-1:0] byte_count_q;
	logic [7:0]            length_q;
	logic [7:0]            command_q;
	logic [7:0]            body0_q;
	logic [7:0]            body1_q;
	logic [7:0]            body2_q;
	logic [7:0]            body4_q;
	logic                  header_good_q;
	logic [15:0]           run_sum_q;
	logic [15:0]           rx_cs_q;

	// Appliance state.
	logic       locked_q;
	logic       power_q;
	logic       eco_q;
	logic [7:0] target_q;

	// Response snapshot taken at frame_end, serialized afterwards.
	logic        resp_active_q;
	logic        resp_query_q;
	logic [4:0]  resp_idx_q;
	logic [7:0]  snap_cmd_q;
	logic        snap_bad_q;
	logic        snap_locked_q;
	logic        snap_power_q;
	logic        snap_eco_q;
	logic [7:0]  snap_target_q;
	logic [7:0]  snap_cabin_q;
	logic [6:0]  snap_pct_q;
	logic [4:0]  snap_volts_q;
	logic [3:0]  snap_tenths_q;
	logic [15:0] snap_cs_q;

	// Output register.
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_bad_q;

	logic              in_xfer;
	logic [CW-1:0]     cnt_w;
	logic [CW-1:0]     n_w;
	logic [7:0]        len_eff;
	logic [CW-1:0]     len_w;
	logic [7:0]        cmd_nx;
	logic [7:0]        body0_nx;
	logic [7:0]        body1_nx;
	logic [7:0]        body2_nx;
	logic [7:0]        body4_nx;
	logic              header_good_nx;
	logic [15:0]       run_sum_nx;
	logic [15:0]       rx_cs_nx;
	logic              frame_kept;
	logic              cmd_is_ack;
	logic              start_query;
	logic              start_ack;
	logic              cs_bad;
	logic [7:0]        target_clamped;
	logic [7:0]        cabin_clamped;
	logic [15:0]       query_sum;
	logic [15:0]       ack_sum;
	logic              out_load;
	logic [4:0]        last_idx;
	logic [7:0]        byte_mux;

	function automatic logic [7:0] clamp_s8(logic signed [7:0] v, logic signed [7:0] lo,
	                                        logic signed [7:0] hi);
		logic signed [7:0] r;
		r = v;
		if (v < lo) r = lo;
		if (v > hi) r = hi;
		return r;
	endfunction

	// A frame_end byte is held off only while a response is still being serialized.
	assign cmd.ready = !(resp_active_q && cmd.frame_end);
	assign in_xfer   = cmd.valid && cmd.ready;

	// Per-byte frame gathering. The length byte is usable in the same cycle it arrives.
	always_comb begin
		cnt_w   = {1'b0, byte_count_q};
		n_w     = cnt_w + CW'(1);
		len_eff = (cnt_w == CW'(2)) ? cmd.rx_byte : length_q;
		len_w   = CW'(len_eff);

		cmd_nx   = (cnt_w == CW'(3)) ? cmd.rx_byte : command_q;
		body0_nx = (cnt_w == CW'(4)) ? cmd.rx_byte : body0_q;
		body1_nx = (cnt_w == CW'(5)) ? cmd.rx_byte : body1_q;
		body2_nx = (cnt_w == CW'(6)) ? cmd.rx_byte : body2_q;
		body4_nx = (cnt_w == CW'(8)) ? cmd.rx_byte : body4_q;

		header_good_nx = header_good_q;
		if (cnt_w < CW'(2) && cmd.rx_byte != SYNC_BYTE) begin
			header_good_nx = 1'b0;
		end

		// Every byte up to the declared length is summed; the checksum bytes are not.
		run_sum_nx = run_sum_q;
		if (cnt_w < CW'(3) || cnt_w <= len_w) begin
			run_sum_nx = run_sum_q + {8'h00, cmd.rx_byte};
		end

		rx_cs_nx = rx_cs_q;
		if (cnt_w >= CW'(3) && cnt_w == CW'(length_q) + CW'(1)) begin
			rx_cs_nx[15:8] = cmd.rx_byte;
		end
		if (cnt_w >= CW'(3) && cnt_w == CW'(length_q) + CW'(2)) begin
			rx_cs_nx[7:0] = cmd.rx_byte;
		end

		cs_bad = (rx_cs_nx != run_sum_nx);

		frame_kept = (n_w >= CW'(6)) && header_good_nx && (len_eff >= MIN_LEN)
			&& (n_w >= len_w + CW'(3));
		cmd_is_ack = cmd_nx inside {OP_BIND, OP_SET, OP_RESET, OP_LEFT, OP_RIGHT};

		start_query = in_xfer && cmd.frame_end && frame_kept && (cmd_nx == OP_QUERY);
		start_ack   = in_xfer && cmd.frame_end && frame_kept && cmd_is_ack;
	end

	// Status frame fields and both frame checksums.
	always_comb begin
		target_clamped = clamp_s8($signed(target_q), TARGET_MIN, TARGET_MAX);
		cabin_clamped  = clamp_s8(cmd.current_temp, CABIN_MIN, CABIN_MAX);
		query_sum = QUERY_SUM_BASE + {15'd0, locked_q} + {15'd0, power_q} + {15'd0, eco_q}
			+ {8'h00, target_clamped} + {8'h00, cabin_clamped}
			+ {9'd0, cmd.battery_percent} + {11'd0, cmd.battery_volts}
			+ {12'd0, cmd.battery_tenths};
		ack_sum = ACK_SUM_BASE + {8'h00, cmd_nx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			length_q      <= '0;
			command_q     <= '0;
			body0_q       <= '0;
			body1_q       <= '0;
			body2_q       <= '0;
			body4_q       <= '0;
			header_good_q <= 1'b1;
			run_sum_q     <= '0;
			rx_cs_q       <= '0;
			locked_q      <= 1'b0;
			power_q       <= 1'b1;
			eco_q         <= 1'b0;
			target_q      <= TARGET_RESET;
		end else if (in_xfer) begin
			if (cmd.frame_end) begin
				byte_count_q  <= '0;
				length_q      <= '0;
				command_q     <= '0;
				body0_q       <= '0;
				body1_q       <= '0;
				body2_q       <= '0;
				body4_q       <= '0;
				header_good_q <= 1'b1;
				run_sum_q     <= '0;
				rx_cs_q       <= '0;
				if (start_ack) begin
					if (cmd_nx == OP_SET && len_eff >= SET_MIN_LEN) begin
						locked_q <= (body0_nx != 8'h00);
						power_q  <= (body1_nx != 8'h00);
						eco_q    <= (body2_nx == 8'h01);
						target_q <= body4_nx;
					end else if (cmd_nx == OP_LEFT && len_eff >= LEFT_MIN_LEN) begin
						target_q <= body0_nx;
					end else if (cmd_nx == OP_RESET) begin
						locked_q <= 1'b0;
						power_q  <= 1'b1;
						eco_q    <= 1'b0;
						target_q <= TARGET_RESET;
					end
				end
			end else begin
				// The count saturates on very long writes.
				if (byte_count_q != '1) begin
					byte_count_q <= byte_count_q + COUNT_BITS'(1);
				end
				if (cnt_w == CW'(2)) begin
					length_q <= cmd.rx_byte;
				end
				command_q     <= cmd_nx;
				body0_q       <= body0_nx;
				body1_q       <= body1_nx;
				body2_q       <= body2_nx;
				body4_q       <= body4_nx;
				header_good_q <= header_good_nx;
				run_sum_q     <= run_sum_nx;
				rx_cs_q       <= rx_cs_nx;
			end
		end
	end

	// Snapshot payload needs no reset.
	always_ff @(posedge clk) begin
		if (start_query || start_ack) begin
			resp_query_q  <= start_query;
			snap_cmd_q    <= cmd_nx;
			snap_bad_q    <= cs_bad;
			snap_locked_q <= locked_q;
			snap_power_q  <= power_q;
			snap_eco_q    <= eco_q;
			snap_target_q <= target_clamped;
			snap_cabin_q  <= cabin_clamped;
			snap_pct_q    <= cmd.battery_percent;
			snap_volts_q  <= cmd.battery_volts;
			snap_tenths_q <= cmd.battery_tenths;
			snap_cs_q     <= start_query ? query_sum : ack_sum;
		end
	end

	// Response byte selection by position in the frame.
	always_comb begin
		last_idx = resp_query_q ? QUERY_LAST_IDX : ACK_LAST_IDX;
		out_load = resp_active_q && (!out_valid_q || resp.ready);
		byte_mux = 8'h00;
		if (resp_query_q) begin
			case (resp_idx_q)
				5'd0, 5'd1: byte_mux = SYNC_BYTE;
				5'd2:       byte_mux = QUERY_LEN_BYTE;
				5'd3:       byte_mux = OP_QUERY;
				5'd4:       byte_mux = {7'd0, snap_locked_q};
				5'd5:       byte_mux = {7'd0, snap_power_q};
				5'd6:       byte_mux = {7'd0, snap_eco_q};
				5'd8:       byte_mux = snap_target_q;
				5'd9:       byte_mux = QRY_BYTE_NINE;
				5'd10:      byte_mux = QRY_BYTE_TEN;
				5'd11:      byte_mux = QRY_BYTE_ELEVEN;
				5'd18:      byte_mux = snap_cabin_q;
				5'd19:      byte_mux = {1'b0, snap_pct_q};
				5'd20:      byte_mux = {3'd0, snap_volts_q};
				5'd21:      byte_mux = {4'd0, snap_tenths_q};
				5'd22:      byte_mux = snap_cs_q[15:8];
				5'd23:      byte_mux = snap_cs_q[7:0];
				default:    byte_mux = 8'h00;
			endcase
		end else begin
			case (resp_idx_q)
				5'd0, 5'd1: byte_mux = SYNC_BYTE;
				5'd2:       byte_mux = ACK_LEN_BYTE;
				5'd3:       byte_mux = snap_cmd_q;
				5'd4:       byte_mux = snap_cs_q[15:8];
				5'd5:       byte_mux = snap_cs_q[7:0];
				default:    byte_mux = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_active_q <= 1'b0;
			resp_idx_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (start_query || start_ack) begin
				resp_active_q <= 1'b1;
				resp_idx_q    <= '0;
			end else if (out_load) begin
				if (resp_idx_q == last_idx) begin
					resp_active_q <= 1'b0;
					resp_idx_q    <= '0;
				end else begin
					resp_idx_q <= resp_idx_q + 5'd1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (resp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= byte_mux;
			out_last_q <= (resp_idx_q == last_idx);
			out_bad_q  <= snap_bad_q;
		end
	end

	assign resp.valid             = out_valid_q;
	assign resp.resp_byte         = out_byte_q;
	assign resp.resp_last         = out_last_q;
	assign resp.checksum_mismatch = out_bad_q;

	// The serializer never runs past the end of the frame being sent.
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		resp_active_q |-> resp_idx_q <= last_idx)
		else $error("response index past frame end");

	// A new response never starts while the previous one is still being sent.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(start_query || start_ack) |-> !resp_active_q)
		else $error("response started while another was active");

	// When the serializer finishes, the output register holds the closing byte.
	a_last_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(resp_active_q) |-> (out_valid_q && out_last_q))
		else $error("serializer finished without a last byte");

	// A closing byte that is taken with nothing pending leaves the output empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q && resp.ready && !resp_active_q) |=> !out_valid_q)
		else $error("output still valid after last transfer");

endmodule
